/* design/ngga_pkg.sv */
// shared constants, types and helpers for the gga position parser
package ngga_pkg;

    localparam int SCAN_WINDOW     = 80;
    localparam int FIELDS_NEEDED   = 12;
    localparam int MAX_TEXT_LENGTH = 2048;

    localparam int HDR_LEN  = 5;
    localparam int HDR_W    = $clog2(HDR_LEN + 1);
    localparam int SP_W     = $clog2(SCAN_WINDOW + 2);
    localparam int FC_W     = $clog2(FIELDS_NEEDED + 1);
    localparam int BC_W     = $clog2(MAX_TEXT_LENGTH + 1);
    localparam int NUM_CAPT = 5;

    // captured field slots and the field numbers that land in them
    localparam int SLOT_LAT      = 0;
    localparam int SLOT_LAT_HEMI = 1;
    localparam int SLOT_LON      = 2;
    localparam int SLOT_LON_HEMI = 3;
    localparam int SLOT_ALT      = 4;
    localparam int FIELD_FIRST   = 1;
    localparam int FIELD_LAST_LL = 4;
    localparam int FIELD_ALT     = 8;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 168;
    localparam int FRAC_W     = 17;
    localparam int MIN_W      = 7;
    localparam int DEG_W      = 9;
    localparam int QUO_W      = 16;

    // splitting constants: value / DIV_FRAC estimated by a reciprocal and corrected once
    localparam int               DIV_FRAC   = 100000;
    localparam int               DIV_MIN    = 100;
    localparam logic [QUO_W-1:0] RECIP_FRAC = QUO_W'((64'd1 << 32) / DIV_FRAC);
    localparam logic [9:0]       RECIP_MIN  = 10'((64'd1 << QUO_W) / DIV_MIN);
    localparam int               SPLIT_STAGES = 5;

    typedef logic [7:0]                  t_char;
    typedef logic [31:0]                 t_word;
    typedef logic [HDR_LEN-1:0][7:0]     t_hdr;
    typedef logic [NUM_CAPT-1:0][31:0]   t_fields;

    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_COMMA = 8'h2C;
    localparam t_char CH_0     = 8'h30;
    localparam t_char CH_9     = 8'h39;
    localparam t_char CH_UP_N  = 8'h4E;
    localparam t_char CH_UP_W  = 8'h57;
    localparam t_char CH_LO_N  = 8'h6E;
    localparam t_char CH_LO_W  = 8'h77;
    localparam t_char CH_UP_S  = 8'h53;
    localparam t_char CH_UP_E  = 8'h45;
    localparam t_char CH_UP_M  = 8'h4D;
    localparam t_char CH_LO_S  = 8'h73;
    localparam t_char CH_LO_E  = 8'h65;
    localparam t_char CH_LO_M  = 8'h6D;

    // element 0 is the first character of the header
    localparam t_hdr HDR_GPGGA = {8'h41, 8'h47, 8'h47, 8'h50, 8'h47};
    localparam t_hdr HDR_GNGGA = {8'h41, 8'h47, 8'h47, 8'h4E, 8'h47};
    localparam logic [HDR_LEN-1:0][HDR_W-1:0] HDR_FAIL = {
        HDR_W'(1), HDR_W'(1), HDR_W'(0), HDR_W'(0), HDR_W'(0)
    };

    typedef struct packed {
        logic            found;
        logic [FC_W-1:0] fcount;
        t_fields         fields;
    } t_ctx_view;

    typedef struct packed {
        logic  fix;
        t_word lat;
        t_word lat_hemi;
        t_word lon;
        t_word lon_hemi;
        t_word alt;
    } t_rec;

    typedef struct packed {
        logic  fix;
        t_word lat_hemi;
        t_word lon_hemi;
        t_word alt;
    } t_pass;

    // substring matcher step with fallback on partial matches
    function automatic logic [HDR_W-1:0] hdr_advance(logic [HDR_W-1:0] j_in, t_char b,
                                                     t_hdr pat);
        logic [HDR_W-1:0] j;
        j = j_in;
        for (int i = 0; i < HDR_LEN; i++) begin
            if (j != '0 && b != pat[j]) begin
                j = HDR_FAIL[j];
            end
        end
        if (b == pat[j]) begin
            j = j + HDR_W'(1);
        end
        return j;
    endfunction

endpackage

/* design/ngga_ctx.sv */
// one header context: header search, then field scan over the window
module ngga_ctx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ngga_pkg::t_hdr     i_pattern,
    input  logic               i_step,
    input  logic               i_clear,
    input  ngga_pkg::t_char    i_byte,
    output ngga_pkg::t_ctx_view o_view
);
    import ngga_pkg::*;

    logic [HDR_W-1:0] r_idx, n_idx, u_idx;
    logic             r_found, n_found, u_found;
    logic [SP_W-1:0]  r_sp, n_sp, u_sp;
    logic             r_skip, n_skip, u_skip;
    logic [FC_W-1:0]  r_fc, n_fc, u_fc;
    t_word            r_acc, n_acc, u_acc;
    t_fields          r_fields, n_fields;
    logic [HDR_W-1:0] w_match;
    logic             w_store;
    t_word            w_store_val;

    assign w_match = hdr_advance(r_idx, i_byte, i_pattern);

    always_comb begin
        u_idx       = r_idx;
        u_found     = r_found;
        u_sp        = r_sp;
        u_skip      = r_skip;
        u_fc        = r_fc;
        u_acc       = r_acc;
        n_fields    = r_fields;
        w_store     = 1'b0;
        w_store_val = '0;
        if (i_step) begin
            if (!r_found) begin
                if (w_match == HDR_W'(HDR_LEN)) begin
                    u_found = 1'b1;
                    u_idx   = '0;
                    u_sp    = '0;
                    u_skip  = 1'b1;
                    u_fc    = '0;
                    u_acc   = '0;
                end else begin
                    u_idx = w_match;
                end
            end else if (r_skip) begin
                u_skip = 1'b0;
            end else if (r_fc < FC_W'(FIELDS_NEEDED) && r_sp < SP_W'(SCAN_WINDOW)) begin
                u_sp = r_sp + SP_W'(1);
                if (i_byte == CH_DOT) begin
                    u_acc = r_acc;
                end else if (i_byte >= CH_0 && i_byte <= CH_9) begin
                    u_acc = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0}
                          + {28'd0, i_byte[3:0]};
                end else if (i_byte == CH_UP_S || i_byte == CH_UP_E || i_byte == CH_LO_S
                          || i_byte == CH_LO_E || i_byte == CH_UP_M || i_byte == CH_LO_M) begin
                    w_store     = 1'b1;
                    w_store_val = '0;
                    u_sp        = r_sp + SP_W'(2);
                    u_skip      = 1'b1;
                end else if (i_byte == CH_UP_N || i_byte == CH_UP_W || i_byte == CH_LO_N
                          || i_byte == CH_LO_W) begin
                    w_store     = 1'b1;
                    w_store_val = 32'd1;
                    u_sp        = r_sp + SP_W'(2);
                    u_skip      = 1'b1;
                end else if (i_byte == CH_COMMA) begin
                    w_store     = 1'b1;
                    w_store_val = r_acc;
                    u_acc       = '0;
                end else begin
                    u_acc = '0;
                end
            end
        end
        if (w_store) begin
            if (r_fc >= FC_W'(FIELD_FIRST) && r_fc <= FC_W'(FIELD_LAST_LL)) begin
                n_fields[3'(r_fc - FC_W'(FIELD_FIRST))] = w_store_val;
            end else if (r_fc == FC_W'(FIELD_ALT)) begin
                n_fields[SLOT_ALT] = w_store_val;
            end
            u_fc = r_fc + FC_W'(1);
        end

        // the result looks at the state after this beat
        o_view.found  = u_found;
        o_view.fcount = u_fc;
        o_view.fields = n_fields;

        if (i_clear) begin
            n_idx   = '0;
            n_found = 1'b0;
            n_sp    = '0;
            n_skip  = 1'b1;
            n_fc    = '0;
            n_acc   = '0;
        end else begin
            n_idx   = u_idx;
            n_found = u_found;
            n_sp    = u_sp;
            n_skip  = u_skip;
            n_fc    = u_fc;
            n_acc   = u_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_found <= 1'b0;
            r_sp    <= '0;
            r_skip  <= 1'b1;
            r_fc    <= '0;
            r_acc   <= '0;
        end else begin
            r_idx   <= n_idx;
            r_found <= n_found;
            r_sp    <= n_sp;
            r_skip  <= n_skip;
            r_fc    <= n_fc;
            r_acc   <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fields <= n_fields;
    end

endmodule

/* design/ngga_split.sv */
// five-stage split of a coordinate into degrees, minutes and fraction
module ngga_split (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  ngga_pkg::t_word               i_value,
    output logic [ngga_pkg::FRAC_W-1:0]   o_fraction,
    output logic [ngga_pkg::MIN_W-1:0]    o_minutes,
    output logic [ngga_pkg::DEG_W-1:0]    o_degrees
);
    import ngga_pkg::*;

    logic [47:0]       r1_prod;
    t_word             r1_val;
    logic [32:0]       r2_back;
    logic [QUO_W-1:0]  r2_q;
    t_word             r2_val;
    logic [QUO_W-1:0]  r3_q, n3_q;
    logic [FRAC_W-1:0] r3_frac, n3_frac;
    logic [25:0]       r4_prod;
    logic [QUO_W-1:0]  r4_q;
    logic [FRAC_W-1:0] r4_frac;
    logic [DEG_W-1:0]  n5_deg;
    logic [MIN_W-1:0]  n5_min;
    logic [32:0]       w_rem;
    logic [9:0]        w_dest;
    logic [QUO_W-1:0]  w_mrem;

    // estimate is low by at most one, so one compare and subtract corrects it
    always_comb begin
        w_rem = {1'b0, r2_val} - r2_back;
        if (w_rem >= 33'(DIV_FRAC)) begin
            n3_q    = r2_q + QUO_W'(1);
            n3_frac = FRAC_W'(w_rem - 33'(DIV_FRAC));
        end else begin
            n3_q    = r2_q;
            n3_frac = FRAC_W'(w_rem);
        end

        w_dest = r4_prod[25:16];
        w_mrem = r4_q - (QUO_W'(w_dest) * QUO_W'(DIV_MIN));
        if (w_mrem >= QUO_W'(DIV_MIN)) begin
            n5_deg = DEG_W'(w_dest + 10'd1);
            n5_min = MIN_W'(w_mrem - QUO_W'(DIV_MIN));
        end else begin
            n5_deg = DEG_W'(w_dest);
            n5_min = MIN_W'(w_mrem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod    <= 48'(i_value) * 48'(RECIP_FRAC);
            r1_val     <= i_value;
            r2_q       <= r1_prod[47:32];
            r2_back    <= 33'(r1_prod[47:32]) * 33'(DIV_FRAC);
            r2_val     <= r1_val;
            r3_q       <= n3_q;
            r3_frac    <= n3_frac;
            r4_prod    <= 26'(r3_q) * 26'(RECIP_MIN);
            r4_q       <= r3_q;
            r4_frac    <= r3_frac;
            o_fraction <= r4_frac;
            o_minutes  <= n5_min;
            o_degrees  <= n5_deg;
        end
    end

endmodule

/* design/nmea_gga_position_parser_top.sv */
// gga position parser top level: input register, two contexts, split pipeline
//
//  channel  | dir | handshake                    | contents
//  ---------+-----+------------------------------+--------------------------------
//  s        | in  | i_s_tvalid / o_s_tready      | text byte, tlast on last byte
//  m        | out | o_m_tvalid / i_m_tready      | one position result per text
//
// one byte is taken every cycle; the last byte of a text needs the result slot free
// a result passes from its last byte through the input register, the context update into
// the result slot, then five stages of the coordinate split
// the split pipeline advances as one whenever the output is empty or being taken
// reset is synchronous, active low, and returns both contexts to header search
module nmea_gga_position_parser_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [ngga_pkg::IN_DATA_W-1:0]    i_s_tdata,  // text_byte
    input  logic                              i_s_tlast,  // end_of_text
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // lat_fraction, lat_minutes, lat_degrees, lat_hemisphere, lon_fraction,
    // lon_minutes, lon_degrees, lon_hemisphere, altitude_digits, zero fill
    output logic [ngga_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    output logic                              o_m_tuser   // fix_found
);
    import ngga_pkg::*;

    logic                    r_in_valid;
    t_char                   r_in_byte;
    logic                    r_in_last;
    logic [BC_W-1:0]         r_bcnt;
    logic                    r_rec_valid;
    t_rec                    r_rec, n_rec;
    logic [SPLIT_STAGES-1:0] r_vld;
    t_pass                   r_pass [SPLIT_STAGES];

    logic      w_en;
    logic      w_rec_free;
    logic      w_take;
    logic      w_step;
    logic      w_clear;
    t_ctx_view w_gp, w_gn, w_sel;
    logic [FRAC_W-1:0] w_lat_frac, w_lon_frac;
    logic [MIN_W-1:0]  w_lat_min, w_lon_min;
    logic [DEG_W-1:0]  w_lat_deg, w_lon_deg;

    assign w_en       = !r_vld[SPLIT_STAGES-1] || i_m_tready;
    assign w_rec_free = !r_rec_valid || w_en;
    assign w_take     = r_in_valid && (!r_in_last || w_rec_free);
    assign o_s_tready = !r_in_valid || w_take;
    assign w_step     = w_take && (r_bcnt < BC_W'(MAX_TEXT_LENGTH));
    assign w_clear    = w_take && r_in_last;

    ngga_ctx u_ctx_gp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pattern (HDR_GPGGA),
        .i_step    (w_step),
        .i_clear   (w_clear),
        .i_byte    (r_in_byte),
        .o_view    (w_gp)
    );

    ngga_ctx u_ctx_gn (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pattern (HDR_GNGGA),
        .i_step    (w_step),
        .i_clear   (w_clear),
        .i_byte    (r_in_byte),
        .o_view    (w_gn)
    );

    // gpgga wins whenever its header turned up
    always_comb begin
        w_sel     = w_gp.found ? w_gp : w_gn;
        n_rec.fix = w_sel.found && (w_sel.fcount == FC_W'(FIELDS_NEEDED));
        if (n_rec.fix) begin
            n_rec.lat      = w_sel.fields[SLOT_LAT];
            n_rec.lat_hemi = w_sel.fields[SLOT_LAT_HEMI];
            n_rec.lon      = w_sel.fields[SLOT_LON];
            n_rec.lon_hemi = w_sel.fields[SLOT_LON_HEMI];
            n_rec.alt      = w_sel.fields[SLOT_ALT];
        end else begin
            n_rec.lat      = '0;
            n_rec.lat_hemi = '0;
            n_rec.lon      = '0;
            n_rec.lon_hemi = '0;
            n_rec.alt      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_bcnt      <= '0;
            r_rec_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_clear) begin
                r_bcnt <= '0;
            end else if (w_step) begin
                r_bcnt <= r_bcnt + BC_W'(1);
            end
            if (w_clear) begin
                r_rec_valid <= 1'b1;
            end else if (w_en) begin
                r_rec_valid <= 1'b0;
            end
            if (w_en) begin
                r_vld <= {r_vld[SPLIT_STAGES-2:0], r_rec_valid};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (w_clear) begin
            r_rec <= n_rec;
        end
        if (w_en) begin
            r_pass[0] <= '{fix: r_rec.fix, lat_hemi: r_rec.lat_hemi,
                           lon_hemi: r_rec.lon_hemi, alt: r_rec.alt};
            for (int i = 1; i < SPLIT_STAGES; i++) begin
                r_pass[i] <= r_pass[i-1];
            end
        end
    end

    ngga_split u_split_lat (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_value    (r_rec.lat),
        .o_fraction (w_lat_frac),
        .o_minutes  (w_lat_min),
        .o_degrees  (w_lat_deg)
    );

    ngga_split u_split_lon (
        .i_clk      (i_clk),
        .i_en       (w_en),
        .i_value    (r_rec.lon),
        .o_fraction (w_lon_frac),
        .o_minutes  (w_lon_min),
        .o_degrees  (w_lon_deg)
    );

    assign o_m_tvalid = r_vld[SPLIT_STAGES-1];
    assign o_m_tuser  = r_pass[SPLIT_STAGES-1].fix;
    assign o_m_tdata  = {6'd0,
                         r_pass[SPLIT_STAGES-1].alt,
                         r_pass[SPLIT_STAGES-1].lon_hemi,
                         w_lon_deg, w_lon_min, w_lon_frac,
                         r_pass[SPLIT_STAGES-1].lat_hemi,
                         w_lat_deg, w_lat_min, w_lat_frac};

    // only a last byte waiting for the result slot may hold off the input
    a_stall_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_in_last && r_rec_valid))
        else $error("input stalled without a pending last beat");

    // a finished record enters the split pipeline when it advances
    a_rec_enters_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rec_valid && w_en) |=> r_vld[0])
        else $error("record lost on its way into the split pipeline");

    // a result without a fix carries only zeros
    a_no_fix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0))
        else $error("no-fix result with non-zero data");

endmodule
